// ===== rtl/fpsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared types and constants for the frame presentation sync clock block.
// ----------------------------------------------------------------------------
package fpsc_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // The speed field is a fixed 16-bit unsigned fixed-point value.
  localparam int unsigned SPEED_W = 16;

  // Quotient bits the divider retires in one cycle.
  localparam int unsigned DIV_BITS_PER_CYC = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FRAME_DUR = 3'd0,
    CFG_FRAME_PERIOD  = 3'd1,
    CFG_MIN_THRESHOLD = 3'd2,
    CFG_MAX_THRESHOLD = 3'd3,
    CFG_DUP_THRESHOLD = 3'd4,
    CFG_REFRESH       = 3'd5
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_MAX_FRAME_DUR = 32'd10000000;
  localparam logic [CFG_W-1:0] RST_FRAME_PERIOD  = 32'd40000;
  localparam logic [CFG_W-1:0] RST_MIN_THRESHOLD = 32'd40000;
  localparam logic [CFG_W-1:0] RST_MAX_THRESHOLD = 32'd100000;
  localparam logic [CFG_W-1:0] RST_DUP_THRESHOLD = 32'd100000;
  localparam logic [CFG_W-1:0] RST_REFRESH       = 32'd10000;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_GAP  = 9'b000000010,
    ST_DIFF = 9'b000000100,
    ST_ADJ  = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_TGT  = 9'b000100000,
    ST_REM  = 9'b001000000,
    ST_LAG  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_e;

endpackage

// ===== rtl/fpsc_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsc_item_if
// Input channel: one frame attempt per transaction.
// ----------------------------------------------------------------------------
interface fpsc_item_if #(
  parameter int unsigned TIME_BITS = 47
);
  logic                        valid;
  logic                        ready;
  logic                        sync_enable;
  logic signed [TIME_BITS-1:0] frame_pts;
  logic signed [TIME_BITS-1:0] master_pts;
  logic [15:0]                 speed;
  logic signed [TIME_BITS-1:0] now_time;

  modport source (
    output valid, sync_enable, frame_pts, master_pts, speed, now_time,
    input  ready
  );

  modport sink (
    input  valid, sync_enable, frame_pts, master_pts, speed, now_time,
    output ready
  );
endinterface

// ===== rtl/fpsc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsc_result_if
// Output channel: one presentation decision per transaction.
// ----------------------------------------------------------------------------
interface fpsc_result_if #(
  parameter int unsigned TIME_BITS = 47
);
  logic                        valid;
  logic                        ready;
  logic                        show_frame;
  logic [31:0]                 wait_time;
  logic signed [TIME_BITS-1:0] applied_delay;

  modport source (
    output valid, show_frame, wait_time, applied_delay,
    input  ready
  );

  modport sink (
    input  valid, show_frame, wait_time, applied_delay,
    output ready
  );
endinterface

// ===== rtl/frame_presentation_sync_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_presentation_sync_clock
// Paces video frames against a master clock: derives the frame delay from
// the timestamp gap, corrects it by the master clock lag, scales it by the
// playback speed and decides whether the frame is shown now or must wait.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  item_i    in         valid / ready      sync_enable, frame_pts, master_pts,
//                                          speed, now_time
//  result_o  out        valid / ready      show_frame, wait_time, applied_delay
//  cfg       in         cfg_we_i           cfg_idx_i, cfg_data_i
//
//  A shown frame passes through the gap, diff, adjust, divide, target,
//  remainder, lag and output steps; an early frame skips the lag step.
//  The speed divider retires 4 quotient bits a cycle.
//  Reset clears the frame timer, the last timestamp and its valid flag and
//  loads the register defaults. The block takes no item while one is in work;
//  a finished result waits in the output register until it is taken.
// ----------------------------------------------------------------------------
module frame_presentation_sync_clock #(
  parameter int unsigned TIME_BITS       = 47,
  parameter int unsigned SPEED_FRAC_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  fpsc_item_if.sink                          item_i,
  fpsc_result_if.source                      result_o,
  input  logic                               cfg_we_i,
  input  logic [fpsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fpsc_pkg::CFG_W-1:0]         cfg_data_i
);
  import fpsc_pkg::*;

  localparam int unsigned W       = TIME_BITS;
  localparam int unsigned CW      = TIME_BITS + 2;
  localparam int unsigned QW      = TIME_BITS - 1 + SPEED_FRAC_BITS;
  localparam int unsigned DIV_CYC = (QW + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC;
  localparam int unsigned QPAD    = DIV_CYC * DIV_BITS_PER_CYC;
  localparam int unsigned CNT_W   = $clog2(DIV_CYC);

  localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

  // Widening helpers for the compare paths.
  function automatic logic signed [CW-1:0] zx(input logic [CFG_W-1:0] v);
    return $signed({{(CW-CFG_W){1'b0}}, v});
  endfunction

  function automatic logic signed [CW-1:0] sx(input logic signed [W-1:0] v);
    return $signed({{2{v[W-1]}}, v});
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] mfd_q, fp_q, minthr_q, maxthr_q, dupthr_q, refresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mfd_q     <= RST_MAX_FRAME_DUR;
      fp_q      <= RST_FRAME_PERIOD;
      minthr_q  <= RST_MIN_THRESHOLD;
      maxthr_q  <= RST_MAX_THRESHOLD;
      dupthr_q  <= RST_DUP_THRESHOLD;
      refresh_q <= RST_REFRESH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_FRAME_DUR: mfd_q     <= cfg_data_i;
        CFG_FRAME_PERIOD:  fp_q      <= cfg_data_i;
        CFG_MIN_THRESHOLD: minthr_q  <= cfg_data_i;
        CFG_MAX_THRESHOLD: maxthr_q  <= cfg_data_i;
        CFG_DUP_THRESHOLD: dupthr_q  <= cfg_data_i;
        CFG_REFRESH:       refresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and persistent state.
  state_e                state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  last_valid_q, last_valid_d;
  logic signed [W-1:0]   last_pts_q, last_pts_d;
  logic signed [W-1:0]   timer_q, timer_d;

  // Captured item and working registers.
  logic                  sync_q, sync_d;
  logic signed [W-1:0]   pts_q, pts_d, master_q, master_d, now_q, now_d;
  logic [SPEED_W-1:0]    speed_q, speed_d;
  logic signed [W-1:0]   delay_q, delay_d, diff_q, diff_d;
  logic signed [W-1:0]   target_q, target_d, wrap_q, wrap_d, tnext_q, tnext_d;
  logic                  show_q, show_d;
  logic [CFG_W-1:0]      wait_q, wait_d;
  logic [QPAD-1:0]       nq_q, nq_d;
  logic [SPEED_W:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Output register.
  logic                  out_show_q, out_show_d;
  logic [CFG_W-1:0]      out_wait_q, out_wait_d;
  logic signed [W-1:0]   out_delay_q, out_delay_d;

  // Master clock correction terms.
  logic signed [CW-1:0] delay_x, diff_x, thr_lo, thr;
  logic                 in_win, shrink, grow, add_diff, dbl_sel;
  logic signed [W-1:0]  adj_delay;

  // Shared saturating adder, operands chosen by the sequencer state.
  logic signed [W-1:0]   op_a, op_b;
  logic                  op_sub;
  logic signed [W:0]     sum_x;
  logic signed [W-1:0]   sum_sat;
  logic signed [CW-1:0]  sum_sx;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state_q)
      ST_GAP:  begin op_a = pts_q;    op_b = last_pts_q; op_sub = 1'b1; end
      ST_DIFF: begin op_a = pts_q;    op_b = master_q;   op_sub = 1'b1; end
      ST_ADJ:  begin op_a = delay_q;  op_b = dbl_sel ? delay_q : diff_q; end
      ST_TGT:  begin op_a = timer_q;  op_b = delay_q; end
      ST_REM:  begin op_a = target_q; op_b = now_q;      op_sub = 1'b1; end
      ST_LAG:  begin op_a = now_q;    op_b = wrap_q;     op_sub = 1'b1; end
      default: ;
    endcase
  end

  assign sum_x   = op_sub ? ($signed({op_a[W-1], op_a}) - $signed({op_b[W-1], op_b}))
                          : ($signed({op_a[W-1], op_a}) + $signed({op_b[W-1], op_b}));
  assign sum_sat = (sum_x[W] != sum_x[W-1]) ? (sum_x[W] ? TMIN : TMAX) : sum_x[W-1:0];
  assign sum_sx  = sx(sum_sat);

  // Nominal delay: frame period clamped to the time range.
  logic signed [W-1:0] fp_sat;
  assign fp_sat = (zx(fp_q) > sx(TMAX)) ? TMAX : $signed(W'(fp_q));

  // Master clock correction rules.
  always_comb begin
    delay_x  = sx(delay_q);
    diff_x   = sx(diff_q);
    thr_lo   = (delay_x < zx(maxthr_q)) ? delay_x : zx(maxthr_q);
    thr      = (thr_lo < zx(minthr_q)) ? zx(minthr_q) : thr_lo;
    in_win   = (diff_x < zx(mfd_q)) && (diff_x > -zx(mfd_q));
    shrink   = (master_q > 0) && in_win && (diff_x <= -thr);
    grow     = (master_q > 0) && in_win && !shrink && (diff_x >= thr);
    add_diff = grow && (delay_x > zx(dupthr_q));
    dbl_sel  = grow && !add_diff;
    if (shrink) begin
      adj_delay = sum_sat[W-1] ? '0 : sum_sat;
    end else if (grow) begin
      adj_delay = sum_sat;
    end else begin
      adj_delay = delay_q;
    end
  end

  // Divider: four restoring steps per cycle on the quotient shift register.
  logic [SPEED_W:0] div_s;
  logic [QPAD-1:0]  nq_nxt;
  logic [SPEED_W:0] rem_nxt;
  logic             q_bit;

  assign div_s = (speed_q == '0) ? (SPEED_W+1)'(1) : {1'b0, speed_q};

  always_comb begin
    nq_nxt  = nq_q;
    rem_nxt = rem_q;
    q_bit   = 1'b0;
    for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
      rem_nxt = {rem_nxt[SPEED_W-1:0], nq_nxt[QPAD-1]};
      q_bit   = (rem_nxt >= div_s);
      if (q_bit) begin
        rem_nxt = rem_nxt - div_s;
      end
      nq_nxt = {nq_nxt[QPAD-2:0], q_bit};
    end
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    last_valid_d = last_valid_q;
    last_pts_d   = last_pts_q;
    timer_d      = timer_q;
    sync_d       = sync_q;
    pts_d        = pts_q;
    master_d     = master_q;
    now_d        = now_q;
    speed_d      = speed_q;
    delay_d      = delay_q;
    diff_d       = diff_q;
    target_d     = target_q;
    wrap_d       = wrap_q;
    tnext_d      = tnext_q;
    show_d       = show_q;
    wait_d       = wait_q;
    nq_d         = nq_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    out_show_d   = out_show_q;
    out_wait_d   = out_wait_q;
    out_delay_d  = out_delay_q;

    // The output register empties when its transaction completes.
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          sync_d   = item_i.sync_enable;
          pts_d    = item_i.frame_pts;
          master_d = item_i.master_pts;
          speed_d  = item_i.speed;
          now_d    = item_i.now_time;
          state_d  = ST_GAP;
        end
      end
      ST_GAP: begin
        // Gap since the last shown frame, if plausible.
        if (last_valid_q && (sum_sx > 0) && (sum_sx <= zx(mfd_q))) begin
          delay_d = sum_sat;
        end else begin
          delay_d = fp_sat;
        end
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        diff_d  = sum_sat;
        state_d = ST_ADJ;
      end
      ST_ADJ: begin
        nq_d    = QPAD'({adj_delay[W-2:0], {SPEED_FRAC_BITS{1'b0}}});
        rem_d   = '0;
        cnt_d   = CNT_W'(DIV_CYC - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        nq_d  = nq_nxt;
        rem_d = rem_nxt;
        if (cnt_q == '0) begin
          delay_d = (|nq_nxt[QPAD-1:W-1]) ? TMAX : $signed({1'b0, nq_nxt[W-2:0]});
          state_d = ST_TGT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_TGT: begin
        target_d = sum_sat;
        wrap_d   = sum_x[W-1:0];
        state_d  = ST_REM;
      end
      ST_REM: begin
        // Early frame: report the time left, bounded by the refresh period.
        if (sync_q && (sum_sx > 0)) begin
          show_d  = 1'b0;
          wait_d  = (sum_sx > zx(refresh_q)) ? refresh_q : sum_sat[CFG_W-1:0];
          state_d = ST_OUT;
        end else begin
          state_d = ST_LAG;
        end
      end
      ST_LAG: begin
        // Snap the timer to now when it lags too far or pacing is off.
        if (!sync_q || ((delay_q != '0) && (sum_sx > zx(maxthr_q)))) begin
          tnext_d = now_q;
        end else begin
          tnext_d = wrap_q;
        end
        show_d  = 1'b1;
        wait_d  = '0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_show_d  = show_q;
          out_wait_d  = wait_q;
          out_delay_d = delay_q;
          if (show_q) begin
            last_pts_d   = pts_q;
            last_valid_d = 1'b1;
            timer_d      = tnext_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      last_valid_q <= 1'b0;
      last_pts_q   <= '0;
      timer_q      <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      last_valid_q <= last_valid_d;
      last_pts_q   <= last_pts_d;
      timer_q      <= timer_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sync_q      <= sync_d;
    pts_q       <= pts_d;
    master_q    <= master_d;
    now_q       <= now_d;
    speed_q     <= speed_d;
    delay_q     <= delay_d;
    diff_q      <= diff_d;
    target_q    <= target_d;
    wrap_q      <= wrap_d;
    tnext_q     <= tnext_d;
    show_q      <= show_d;
    wait_q      <= wait_d;
    nq_q        <= nq_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    out_show_q  <= out_show_d;
    out_wait_q  <= out_wait_d;
    out_delay_q <= out_delay_d;
  end

  // Channel outputs.
  assign item_i.ready           = (state_q == ST_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.show_frame    = out_show_q;
  assign result_o.wait_time     = out_wait_q;
  assign result_o.applied_delay = out_delay_q;

  // A shown frame always leaves a valid previous timestamp behind.
  a_shown_sets_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_show_q) |-> last_valid_q)
    else $error("shown frame without valid last timestamp");

  // A shown frame reports no wait; an early one never exceeds the refresh period.
  a_shown_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_show_q) |-> (out_wait_q == '0))
    else $error("shown frame with nonzero wait");

  a_wait_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_show_q) |-> (out_wait_q <= refresh_q))
    else $error("wait time above refresh period");

  // The scaled delay is never negative.
  a_delay_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !out_delay_q[W-1])
    else $error("negative applied delay");

  // The divider keeps iterating until its count runs out.
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && (cnt_q != '0)) |=> (state_q == ST_DIV))
    else $error("divider left early");

  // An accepted item starts the sequence at the gap step.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> (state_q == ST_GAP))
    else $error("accepted item did not start processing");

endmodule
